[rtl/core/assert_macros.svh]
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds every cycle outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/vdef_pkg.sv]
// shared types, constants and lookup functions of the deblocking edge filter
package vdef_pkg;

  typedef struct packed {
    logic [5:0]  qp_fallback;
    logic [5:0]  qp_side_q;
    logic [5:0]  qp_side_p;
    logic [1:0]  strength;
    logic        is_luma;
    logic [63:0] row3_pixels;
    logic [63:0] row2_pixels;
    logic [63:0] row1_pixels;
    logic [63:0] row0_pixels;
  } vdef_in_t;

  typedef struct packed {
    logic [1:0]  filter_used;
    logic [63:0] out_row3;
    logic [63:0] out_row2;
    logic [63:0] out_row1;
    logic [63:0] out_row0;
  } vdef_out_t;

  typedef enum logic [1:0] {
    MODE_PASS   = 2'd0,
    MODE_NORMAL = 2'd1,
    MODE_STRONG = 2'd2,
    MODE_CHROMA = 2'd3
  } vdef_mode_t;

  localparam int unsigned NumRows = 4;

  // per item parameters after the qp stage
  typedef struct packed {
    logic       is_luma;
    logic       bs_nz;
    logic [7:0] beta;
    logic [4:0] tc;
  } vdef_par_t;

  function automatic logic [4:0] tc_lut(input logic [5:0] qp);
    logic [4:0] v;
    begin
      unique case (qp)
        6'd18, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25, 6'd26: v = 5'd1;
        6'd27, 6'd28, 6'd29, 6'd30: v = 5'd2;
        6'd31, 6'd32, 6'd33, 6'd34: v = 5'd3;
        6'd35, 6'd36, 6'd37: v = 5'd4;
        6'd38, 6'd39: v = 5'd5;
        6'd40, 6'd41: v = 5'd6;
        6'd42: v = 5'd7;
        6'd43: v = 5'd8;
        6'd44: v = 5'd9;
        6'd45: v = 5'd10;
        6'd46: v = 5'd11;
        6'd47: v = 5'd13;
        6'd48: v = 5'd14;
        6'd49: v = 5'd16;
        6'd50: v = 5'd18;
        6'd51: v = 5'd20;
        6'd52: v = 5'd22;
        6'd53: v = 5'd24;
        default: v = 5'd0;
      endcase
      return v;
    end
  endfunction

  function automatic logic [5:0] chroma_qp(input logic [5:0] qpw);
    logic [5:0] v;
    begin
      unique case (qpw)
        6'd30: v = 6'd29;
        6'd31: v = 6'd30;
        6'd32: v = 6'd31;
        6'd33: v = 6'd32;
        6'd34, 6'd35: v = 6'd33;
        6'd36, 6'd37: v = 6'd34;
        6'd38, 6'd39: v = 6'd35;
        6'd40, 6'd41: v = 6'd36;
        6'd42, 6'd43: v = 6'd37;
        default: v = (qpw < 6'd30) ? qpw : qpw - 6'd6;
      endcase
      return v;
    end
  endfunction

  function automatic logic [7:0] beta_lut(input logic [5:0] qp);
    logic [7:0] v;
    begin
      if (qp >= 6'd16 && qp <= 6'd28) v = {2'b00, qp} - 8'd10;
      else if (qp >= 6'd29 && qp <= 6'd51) v = {1'b0, qp, 1'b0} - 8'd38;
      else v = 8'd0;
      return v;
    end
  endfunction

  function automatic logic [7:0] sat8(input logic signed [11:0] v);
    logic [7:0] r;
    begin
      if (v < 0) r = 8'd0;
      else if (v > 12'sd255) r = 8'd255;
      else r = v[7:0];
      return r;
    end
  endfunction

  function automatic logic signed [11:0] clip3(input logic signed [11:0] v,
                                               input logic signed [11:0] lo,
                                               input logic signed [11:0] hi);
    logic signed [11:0] r;
    begin
      if (v < lo) r = lo;
      else if (v > hi) r = hi;
      else r = v;
      return r;
    end
  endfunction

endpackage

[rtl/core/vdef_param.sv]
// stage 1: qp selection, averaging, chroma mapping and beta/tc lookup
module vdef_param (
  input  logic [5:0]          qp_side_p,
  input  logic [5:0]          qp_side_q,
  input  logic [5:0]          qp_fallback,
  input  logic                is_luma,
  input  logic [1:0]          strength,
  output vdef_pkg::vdef_par_t par
);
  import vdef_pkg::*;

  logic [5:0] qp_p, qp_q, qpw, qpc;
  logic [6:0] qsum;

  always_comb begin
    qp_p = (qp_side_p == 6'd0) ? qp_fallback : qp_side_p;
    qp_q = (qp_side_q == 6'd0) ? qp_fallback : qp_side_q;
    qsum = {1'b0, qp_p} + {1'b0, qp_q} + 7'd1;
    qpw  = qsum[6:1];
    qpc  = chroma_qp(qpw);
    par.is_luma = is_luma;
    par.bs_nz   = (strength != 2'd0);
    par.beta    = beta_lut(qpw);
    par.tc      = tc_lut(is_luma ? qpw : qpc);
  end
endmodule

[rtl/core/vdef_decide.sv]
// stage 2: strong/normal decision and mode select
module vdef_decide (
  input  logic [63:0]         row0,
  input  logic [63:0]         row3,
  input  vdef_pkg::vdef_par_t par,
  output logic [1:0]          mode
);
  import vdef_pkg::*;

  function automatic logic row_ok(input logic [63:0] x, input logic [7:0] beta,
                                  input logic [4:0] tc);
    logic signed [11:0] v [0:7];
    logic signed [11:0] dp, dq, a, b, c;
    logic [7:0] lim;
    begin
      for (int k = 0; k < 8; k++) v[k] = {4'd0, x[8*k +: 8]};
      dp = v[1] + v[3] - 12'sd2 * v[2];
      dq = v[6] + v[4] - 12'sd2 * v[5];
      if (dp < 0) dp = -dp;
      if (dq < 0) dq = -dq;
      a = v[3] - v[0];
      b = v[4] - v[7];
      c = v[3] - v[4];
      if (a < 0) a = -a;
      if (b < 0) b = -b;
      if (c < 0) c = -c;
      lim = ({3'd0, tc} * 8'd3 + 8'd1) >> 1;
      return (12'sd2 * (dp + dq) < $signed({4'd0, beta >> 2}))
          && (a + b < $signed({4'd0, beta >> 3}))
          && (c < $signed({4'd0, lim}));
    end
  endfunction

  always_comb begin
    if (!par.bs_nz) mode = MODE_PASS;
    else if (!par.is_luma) mode = MODE_CHROMA;
    else if (row_ok(row0, par.beta, par.tc) && row_ok(row3, par.beta, par.tc))
      mode = MODE_STRONG;
    else mode = MODE_NORMAL;
  end
endmodule

[rtl/core/vdef_row.sv]
// stage 3: filters one row for the chosen mode
module vdef_row (
  input  logic [63:0] row_in,
  input  logic [1:0]  mode,
  input  logic [4:0]  tc,
  output logic [63:0] row_out
);
  import vdef_pkg::*;

  logic signed [11:0] p3, p2, p1, p0, q0, q1, q2, q3, t, t2, th;
  logic signed [11:0] d, dp, dq, pc, qc;
  logic signed [11:0] np [0:2];
  logic signed [11:0] nq [0:2];
  logic signed [11:0] op [0:2];
  logic signed [11:0] oq [0:2];
  logic signed [11:0] ref_p [0:2];
  logic signed [11:0] ref_q [0:2];

  always_comb begin
    p3 = {4'd0, row_in[7:0]};   p2 = {4'd0, row_in[15:8]};
    p1 = {4'd0, row_in[23:16]}; p0 = {4'd0, row_in[31:24]};
    q0 = {4'd0, row_in[39:32]}; q1 = {4'd0, row_in[47:40]};
    q2 = {4'd0, row_in[55:48]}; q3 = {4'd0, row_in[63:56]};
    t  = {7'd0, tc};
    t2 = t <<< 1;
    th = t >>> 1;
    row_out = row_in;
    d = '0; dp = '0; dq = '0;
    pc = p2 + p1 + p0 + q0 + 12'sd2;
    qc = q2 + q1 + q0 + p0 + 12'sd2;
    ref_p[0] = p0; ref_p[1] = p1; ref_p[2] = p2;
    ref_q[0] = q0; ref_q[1] = q1; ref_q[2] = q2;
    np[0] = (pc + p1 + p0 + q0 + q1 + 12'sd2) >>> 3;
    np[1] = pc >>> 2;
    np[2] = (pc + 12'sd2 * p3 + 12'sd2 * p2 + 12'sd2) >>> 3;
    nq[0] = (qc + q1 + q0 + p0 + p1 + 12'sd2) >>> 3;
    nq[1] = qc >>> 2;
    nq[2] = (qc + 12'sd2 * q3 + 12'sd2 * q2 + 12'sd2) >>> 3;
    for (int k = 0; k < 3; k++) begin
      op[k] = clip3(np[k], {4'd0, sat8(ref_p[k] - t2)}, {4'd0, sat8(ref_p[k] + t2)});
      oq[k] = clip3(nq[k], {4'd0, sat8(ref_q[k] - t2)}, {4'd0, sat8(ref_q[k] + t2)});
    end
    unique case (mode)
      MODE_CHROMA: begin
        d = clip3(((q0 - p0) * 12'sd4 + p1 - q1 + 12'sd4) >>> 3, -t, t);
        row_out[31:24] = sat8(p0 + d);
        row_out[39:32] = sat8(q0 - d);
      end
      MODE_STRONG: begin
        row_out[31:24] = op[0][7:0]; row_out[23:16] = op[1][7:0];
        row_out[15:8]  = op[2][7:0];
        row_out[39:32] = oq[0][7:0]; row_out[47:40] = oq[1][7:0];
        row_out[55:48] = oq[2][7:0];
      end
      MODE_NORMAL: begin
        // sum can exceed 12 bits before the shift, so it is formed at full width
        d  = clip3(12'((9 * (q0 - p0) - 3 * (q1 - p1) + 8) >>> 4), -t, t);
        dp = clip3((((p2 + p0 + 12'sd1) >>> 1) - p1 + d) >>> 1, -th, th);
        dq = clip3((((q2 + q0 + 12'sd1) >>> 1) - q1 - d) >>> 1, -th, th);
        row_out[31:24] = sat8(p0 + d);
        row_out[39:32] = sat8(q0 - d);
        row_out[23:16] = sat8(p1 + dp);
        row_out[47:40] = sat8(q1 + dq);
      end
      default: row_out = row_in;
    endcase
  end
endmodule

[rtl/core/video_deblocking_edge_filter.sv]
// Deblocking filter for one vertical 4x4|4x4 edge of 8-bit pixels. One edge is
// accepted per cycle and its result passes through the stages in order: stage 1 derives
// the averaged qp and looks up beta and tc, stage 2 makes the strong/normal
// decision from rows 0 and 3, stage 3 filters all four rows in parallel. A
// stalled output holds the whole pipeline; in_ready is high whenever the last
// stage is empty or is being drained, so throughput is one item per cycle unless the output stalls.
module video_deblocking_edge_filter (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  vdef_pkg::vdef_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output vdef_pkg::vdef_out_t out_data
);
  import vdef_pkg::*;

  logic       v1_r, v2_r, v3_r;
  logic       adv;
  vdef_in_t   d1_r, d2_r;
  vdef_par_t  par, par1_r, par2_r;
  logic [1:0] mode, mode2_r;
  vdef_out_t  o3_r;
  logic [63:0] rows_in [0:NumRows-1];
  logic [63:0] rows_out [0:NumRows-1];

  assign adv      = !v3_r || out_ready;
  assign in_ready = adv;

  vdef_param u_param (
    .qp_side_p(in_data.qp_side_p), .qp_side_q(in_data.qp_side_q),
    .qp_fallback(in_data.qp_fallback), .is_luma(in_data.is_luma),
    .strength(in_data.strength), .par(par)
  );

  vdef_decide u_decide (
    .row0(d1_r.row0_pixels), .row3(d1_r.row3_pixels), .par(par1_r), .mode(mode)
  );

  assign rows_in[0] = d2_r.row0_pixels;
  assign rows_in[1] = d2_r.row1_pixels;
  assign rows_in[2] = d2_r.row2_pixels;
  assign rows_in[3] = d2_r.row3_pixels;

  for (genvar r = 0; r < NumRows; r++) begin : g_row
    vdef_row u_row (
      .row_in(rows_in[r]), .mode(mode2_r), .tc(par2_r.tc), .row_out(rows_out[r])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d1_r    <= in_data;
      par1_r  <= par;
      d2_r    <= d1_r;
      par2_r  <= par1_r;
      mode2_r <= mode;
      o3_r.out_row0    <= rows_out[0];
      o3_r.out_row1    <= rows_out[1];
      o3_r.out_row2    <= rows_out[2];
      o3_r.out_row3    <= rows_out[3];
      o3_r.filter_used <= mode2_r;
    end
  end

  assign out_valid = v3_r;
  assign out_data  = o3_r;
endmodule

[rtl/core/vdef_checker.sv]
// port-level checker for the deblocking edge filter, bound to the top level
`include "assert_macros.svh"

module vdef_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input vdef_pkg::vdef_out_t out_data
);
  import vdef_pkg::*;

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")
  `ASSERT_ALWAYS(a_ready_stall, clk, rst_n, !(out_valid && !out_ready) || !in_ready, "input taken while output stalled")
  `ASSERT_ALWAYS(a_ready_free, clk, rst_n, out_valid || in_ready, "input blocked with empty output")
endmodule

bind video_deblocking_edge_filter vdef_checker u_vdef_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

[bench/vdef_edge_checker.sv]
// checker: predicts filtered edges from accepted items and compares results
module vdef_edge_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  vdef_pkg::vdef_in_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  vdef_pkg::vdef_out_t out_data,
  output int                  fail_count,
  output int                  pending
);
  import vdef_pkg::*;

  vdef_out_t edge_q[$];

  function automatic int tc_from_qp(int qp);
    int tbl[64];
    tbl = '{0,0,0,0,0,0,0,0,0,0, 0,0,0,0,0,0,0,0,1,1,
            1,1,1,1,1,1,1,2,2,2, 2,3,3,3,3,4,4,4,5,5,
            6,6,7,8,9,10,11,13,14,16, 18,20,22,24,0,0,0,0,0,0,
            0,0,0,0};
    return tbl[qp & 63];
  endfunction

  function automatic int beta_from_qp(int qp);
    if (qp >= 16 && qp <= 28) return qp - 10;
    if (qp >= 29 && qp <= 51) return 2 * qp - 38;
    return 0;
  endfunction

  function automatic int lim(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic int floor_shr(int v, int n);
    return v >>> n;
  endfunction

  function automatic int absval(int v);
    return v < 0 ? -v : v;
  endfunction

  function automatic vdef_out_t filter_edge(vdef_in_t it);
    int px[4][8];
    logic [63:0] rows[4];
    int qp_p, qp_q, qpw, qpc, beta, tc, t2, th, thr;
    int p0, p1, p2, p3, q0, q1, q2, q3, d, dp, dq, pc, qc, ds, dqq;
    int cmap[14];
    bit strong_ok;
    vdef_mode_t mode;
    vdef_out_t res;
    cmap = '{29,30,31,32,33,33,34,34,35,35,36,36,37,37};
    rows[0] = it.row0_pixels; rows[1] = it.row1_pixels;
    rows[2] = it.row2_pixels; rows[3] = it.row3_pixels;
    for (int r = 0; r < 4; r++)
      for (int k = 0; k < 8; k++) px[r][k] = rows[r][8*k +: 8];
    qp_p = it.qp_side_p == 0 ? it.qp_fallback : it.qp_side_p;
    qp_q = it.qp_side_q == 0 ? it.qp_fallback : it.qp_side_q;
    qpw = (qp_p + qp_q + 1) >> 1;
    if (qpw >= 30 && qpw <= 43) qpc = cmap[qpw - 30];
    else if (qpw < 30) qpc = qpw;
    else qpc = qpw - 6;
    beta = beta_from_qp(qpw);
    tc = tc_from_qp(it.is_luma ? qpw : qpc);
    mode = MODE_PASS;
    if (it.strength != 0 && !it.is_luma) begin
      mode = MODE_CHROMA;
      for (int r = 0; r < 4; r++) begin
        p0 = px[r][3]; p1 = px[r][2]; q0 = px[r][4]; q1 = px[r][5];
        d = lim(floor_shr((q0 - p0) * 4 + p1 - q1 + 4, 3), -tc, tc);
        px[r][3] = lim(p0 + d, 0, 255);
        px[r][4] = lim(q0 - d, 0, 255);
      end
    end else if (it.strength != 0) begin
      strong_ok = 1;
      thr = (3 * tc + 1) >> 1;
      for (int k = 0; k < 2; k++) begin
        int r;
        r = k == 0 ? 0 : 3;
        ds = absval(px[r][1] + px[r][3] - 2 * px[r][2]);
        dqq = absval(px[r][6] + px[r][4] - 2 * px[r][5]);
        if (!((2 * (ds + dqq) < (beta >> 2)) &&
              (absval(px[r][3] - px[r][0]) + absval(px[r][4] - px[r][7]) < (beta >> 3)) &&
              (absval(px[r][3] - px[r][4]) < thr)))
          strong_ok = 0;
      end
      if (strong_ok) begin
        mode = MODE_STRONG;
        t2 = 2 * tc;
        for (int r = 0; r < 4; r++) begin
          p3 = px[r][0]; p2 = px[r][1]; p1 = px[r][2]; p0 = px[r][3];
          q0 = px[r][4]; q1 = px[r][5]; q2 = px[r][6]; q3 = px[r][7];
          pc = p2 + p1 + p0 + q0 + 2;
          qc = q2 + q1 + q0 + p0 + 2;
          px[r][3] = lim((pc + p1 + p0 + q0 + q1 + 2) >> 3,
                         lim(p0 - t2, 0, 255), lim(p0 + t2, 0, 255));
          px[r][2] = lim(pc >> 2, lim(p1 - t2, 0, 255), lim(p1 + t2, 0, 255));
          px[r][1] = lim((pc + 2 * p3 + 2 * p2 + 2) >> 3,
                         lim(p2 - t2, 0, 255), lim(p2 + t2, 0, 255));
          px[r][4] = lim((qc + q1 + q0 + p0 + p1 + 2) >> 3,
                         lim(q0 - t2, 0, 255), lim(q0 + t2, 0, 255));
          px[r][5] = lim(qc >> 2, lim(q1 - t2, 0, 255), lim(q1 + t2, 0, 255));
          px[r][6] = lim((qc + 2 * q3 + 2 * q2 + 2) >> 3,
                         lim(q2 - t2, 0, 255), lim(q2 + t2, 0, 255));
        end
      end else begin
        mode = MODE_NORMAL;
        th = tc >> 1;
        for (int r = 0; r < 4; r++) begin
          p2 = px[r][1]; p1 = px[r][2]; p0 = px[r][3];
          q0 = px[r][4]; q1 = px[r][5]; q2 = px[r][6];
          d = lim(floor_shr(9 * (q0 - p0) - 3 * (q1 - p1) + 8, 4), -tc, tc);
          dp = lim(floor_shr(((p2 + p0 + 1) >> 1) - p1 + d, 1), -th, th);
          dq = lim(floor_shr(((q2 + q0 + 1) >> 1) - q1 - d, 1), -th, th);
          px[r][3] = lim(p0 + d, 0, 255);
          px[r][4] = lim(q0 - d, 0, 255);
          px[r][2] = lim(p1 + dp, 0, 255);
          px[r][5] = lim(q1 + dq, 0, 255);
        end
      end
    end
    for (int r = 0; r < 4; r++)
      for (int k = 0; k < 8; k++) rows[r][8*k +: 8] = px[r][k][7:0];
    res.out_row0 = rows[0]; res.out_row1 = rows[1];
    res.out_row2 = rows[2]; res.out_row3 = rows[3];
    res.filter_used = mode;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    vdef_out_t want;
    if (rst_n && in_valid && in_ready) edge_q.push_back(filter_edge(in_data));
    if (rst_n && out_valid && out_ready) begin
      if (edge_q.size() == 0) begin
        report_mismatch("unexpected item", out_data.out_row0, 64'd0);
      end else begin
        want = edge_q.pop_front();
        if (out_data.out_row0 !== want.out_row0)
          report_mismatch("row0", out_data.out_row0, want.out_row0);
        if (out_data.out_row1 !== want.out_row1)
          report_mismatch("row1", out_data.out_row1, want.out_row1);
        if (out_data.out_row2 !== want.out_row2)
          report_mismatch("row2", out_data.out_row2, want.out_row2);
        if (out_data.out_row3 !== want.out_row3)
          report_mismatch("row3", out_data.out_row3, want.out_row3);
        if (out_data.filter_used !== want.filter_used)
          report_mismatch("filter_used", 64'(out_data.filter_used), 64'(want.filter_used));
      end
    end
    pending = edge_q.size();
  end
endmodule

[bench/video_deblocking_edge_filter_tb.sv]
// testbench top: edge stimulus, stalls, watchdog and verdict
module video_deblocking_edge_filter_tb;
  import vdef_pkg::*;

  localparam int NumDirected = 24;
  localparam int NumRandom   = 1430;
  localparam int QuietLimit  = 2000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  vdef_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  vdef_out_t out_data;
  int        fail_count;
  int        pending;
  int        quiet_cycles;
  bit        calm;
  bit        hold_sink;

  video_deblocking_edge_filter u_dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  vdef_edge_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data), .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int lim8(int v);
    return v < 0 ? 0 : (v > 255 ? 255 : v);
  endfunction

  // smooth rows push luma toward the strong filter
  function automatic logic [63:0] make_row(int kind);
    logic [63:0] r;
    int base, step;
    base = $urandom_range(0, 255);
    step = $urandom_range(0, 6) - 3;
    for (int k = 0; k < 8; k++) begin
      case (kind)
        0: r[8*k +: 8] = 8'($urandom);
        1: r[8*k +: 8] = 8'(lim8(base + step * k + $urandom_range(0, 2)));
        default: r[8*k +: 8] = k < 4 ? 8'(base) : 8'(lim8(base + step * 8));
      endcase
    end
    return r;
  endfunction

  function automatic vdef_in_t random_edge();
    vdef_in_t it;
    int kind;
    kind = $urandom_range(0, 2);
    it.row0_pixels = make_row(kind);
    it.row1_pixels = make_row(kind);
    it.row2_pixels = make_row(kind);
    it.row3_pixels = make_row(kind);
    it.is_luma = 1'($urandom);
    it.strength = 2'($urandom);
    it.qp_side_p = $urandom_range(0, 7) == 0 ? 6'd0 : 6'($urandom);
    it.qp_side_q = $urandom_range(0, 7) == 0 ? 6'd0 : 6'($urandom);
    it.qp_fallback = 6'($urandom);
    return it;
  endfunction

  function automatic vdef_in_t directed_edge(int n);
    vdef_in_t it;
    logic [63:0] flat;
    it = random_edge();
    flat = {8{8'($urandom_range(0, 255))}};
    case (n % 8)
      0: begin it.row0_pixels = '0; it.row1_pixels = '0; it.row2_pixels = '0;
        it.row3_pixels = '0; end
      1: begin it.row0_pixels = '1; it.row1_pixels = '1; it.row2_pixels = '1;
        it.row3_pixels = '1; end
      2: begin it.row0_pixels = 64'hffffffff00000000; it.row1_pixels = 64'hffffffff00000000;
        it.row2_pixels = 64'h00000000ffffffff; it.row3_pixels = 64'h00000000ffffffff; end
      3: begin it.row0_pixels = flat; it.row1_pixels = flat; it.row2_pixels = flat;
        it.row3_pixels = flat; end
      default: ;
    endcase
    it.is_luma = n[0];
    it.strength = 2'(n >> 1);
    case (n / 8)
      0: begin it.qp_side_p = 6'd63; it.qp_side_q = 6'd63; end
      1: begin it.qp_side_p = 6'd0; it.qp_side_q = 6'd0; it.qp_fallback = 6'(40 + n); end
      default: begin it.qp_side_p = 6'(n * 2 + 1); it.qp_side_q = 6'(n * 2); end
    endcase
    return it;
  endfunction

  task automatic send_edge(vdef_in_t it, bit allow_gaps);
    if (allow_gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // receiver backpressure
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_sink) begin
        out_ready <= 1'b0;
        repeat (60) @(posedge clk);
        hold_sink = 0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // watchdog on quiet stretches
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    calm = 0;
    hold_sink = 0;
    quiet_cycles = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int n = 0; n < NumDirected; n++) send_edge(directed_edge(n), 0);
    for (int n = 0; n < NumRandom; n++) begin
      if (n == 200) hold_sink = 1;
      if (n == 500) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      if (n == NumRandom - 200) calm = 1;
      send_edge(random_edge(), !calm);
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
